/* rtl/b128_pkg.sv */
package b128_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int E_W = 20;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [14:0] EXP_MAX = 15'h7fff;
    localparam logic [47:0] QUIET_HI = 48'h8000_0000_0000;
    localparam logic signed [E_W-1:0] E_BIAS = 20'sd16383;
    localparam logic signed [E_W-1:0] E_OVF = 20'sd32767;

    typedef enum logic [1:0] {
        K_SPECIAL,
        K_ADD,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        a_sign;
        logic [14:0] a_exponent;
        logic [47:0] a_frac_high;
        logic [63:0] a_frac_low;
        logic        b_sign;
        logic [14:0] b_exponent;
        logic [47:0] b_frac_high;
        logic [63:0] b_frac_low;
    } t_req;

    typedef struct packed {
        logic        res_neg;
        logic [14:0] res_exponent;
        logic [47:0] res_frac_high;
        logic [63:0] res_frac_low;
    } t_res;

    typedef struct packed {
        t_kind                  kind;
        logic                   sign;
        logic                   eff_sub;
        t_res                   res;
        logic [112:0]           xsig;
        logic signed [E_W-1:0]  ex;
        logic [112:0]           ysig;
        logic signed [E_W-1:0]  ey;
    } t_job;

endpackage

/* rtl/b128_front.sv */
module b128_front (
    input  b128_pkg::t_req i_req,
    output b128_pkg::t_job o_job
);
    import b128_pkg::*;

    logic        bs;
    logic        a_max, b_max, a_fz, b_fz;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        swap;
    logic [112:0] a_sig, b_sig;
    logic signed [E_W-1:0] a_e, b_e;
    t_res        dnan, res_a, res_b, res_inf, res_zero;

    always_comb begin
        bs = i_req.b_sign ^ (i_req.opcode == OP_SUB);
        a_max = i_req.a_exponent == EXP_MAX;
        b_max = i_req.b_exponent == EXP_MAX;
        a_fz = (i_req.a_frac_high == '0) && (i_req.a_frac_low == '0);
        b_fz = (i_req.b_frac_high == '0) && (i_req.b_frac_low == '0);
        a_nan = a_max && !a_fz;
        b_nan = b_max && !b_fz;
        a_inf = a_max && a_fz;
        b_inf = b_max && b_fz;
        a_zero = (i_req.a_exponent == '0) && a_fz;
        b_zero = (i_req.b_exponent == '0) && b_fz;
        a_sig = {i_req.a_exponent != '0, i_req.a_frac_high, i_req.a_frac_low};
        b_sig = {i_req.b_exponent != '0, i_req.b_frac_high, i_req.b_frac_low};
        a_e = (i_req.a_exponent != '0) ? E_W'(i_req.a_exponent) : E_W'(1);
        b_e = (i_req.b_exponent != '0) ? E_W'(i_req.b_exponent) : E_W'(1);
        swap = {i_req.b_exponent, i_req.b_frac_high, i_req.b_frac_low}
             > {i_req.a_exponent, i_req.a_frac_high, i_req.a_frac_low};

        dnan = '{1'b0, EXP_MAX, QUIET_HI, 64'd0};
        res_a = '{i_req.a_sign, i_req.a_exponent, i_req.a_frac_high, i_req.a_frac_low};
        res_b = '{bs, i_req.b_exponent, i_req.b_frac_high, i_req.b_frac_low};
        res_inf = '{i_req.a_sign ^ bs, EXP_MAX, 48'd0, 64'd0};
        res_zero = '{i_req.a_sign ^ bs, 15'd0, 48'd0, 64'd0};

        o_job = '0;
        o_job.kind = K_SPECIAL;
        o_job.sign = i_req.a_sign ^ bs;
        o_job.xsig = a_sig;
        o_job.ex = a_e;
        o_job.ysig = b_sig;
        o_job.ey = b_e;

        if (a_nan) begin
            o_job.res = res_a;
            o_job.res.res_frac_high = i_req.a_frac_high | QUIET_HI;
        end else if (b_nan) begin
            o_job.res = res_b;
            o_job.res.res_frac_high = i_req.b_frac_high | QUIET_HI;
        end else begin
            case (i_req.opcode)
                OP_ADD, OP_SUB: begin
                    if (a_inf) begin
                        o_job.res = (b_inf && (i_req.a_sign != bs)) ? dnan : res_a;
                    end else if (b_inf) begin
                        o_job.res = res_b;
                    end else if (a_zero && b_zero) begin
                        o_job.res = '{i_req.a_sign & bs, 15'd0, 48'd0, 64'd0};
                    end else if (a_zero) begin
                        o_job.res = res_b;
                    end else if (b_zero) begin
                        o_job.res = res_a;
                    end else begin
                        o_job.kind = K_ADD;
                        o_job.eff_sub = i_req.a_sign != bs;
                        if (swap) begin
                            o_job.sign = bs;
                            o_job.xsig = b_sig;
                            o_job.ex = b_e;
                            o_job.ysig = a_sig;
                            o_job.ey = a_e;
                        end else begin
                            o_job.sign = i_req.a_sign;
                        end
                    end
                end
                OP_MUL: begin
                    if (a_inf || b_inf) begin
                        o_job.res = (a_zero || b_zero) ? dnan : res_inf;
                    end else if (a_zero || b_zero) begin
                        o_job.res = res_zero;
                    end else begin
                        o_job.kind = K_MUL;
                    end
                end
                default: begin
                    if (a_inf) begin
                        o_job.res = b_inf ? dnan : res_inf;
                    end else if (b_inf) begin
                        o_job.res = res_zero;
                    end else if (b_zero) begin
                        o_job.res = a_zero ? dnan : res_inf;
                    end else if (a_zero) begin
                        o_job.res = res_zero;
                    end else begin
                        o_job.kind = K_DIV;
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/b128_queue.sv */
module b128_queue #(
    parameter int DEPTH = b128_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b128_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b128_pkg::t_job o_job
);
    import b128_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/b128_back.sv */
module b128_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  b128_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_strobe,
    output b128_pkg::t_res o_res
);
    import b128_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_A,
        S_PRE_B,
        S_ADD_ALIGN,
        S_ADD_SUM,
        S_MUL,
        S_DIV,
        S_NORM,
        S_JAM,
        S_ROUND
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    logic                  r_sign, r_sub;
    logic [127:0]          r_sig, r_ay;
    logic signed [E_W-1:0] r_e, r_ex, r_ey;
    logic [112:0]          r_x, r_y, r_ysrc, r_mq;
    logic [113:0]          r_acc, r_rem;
    logic [126:0]          r_q;
    logic [6:0]            r_cnt;
    logic                  r_strobe;
    t_res                  r_res;

    logic [113:0]          n_mul_sum, n_div_t, n_div_d;
    logic                  n_div_ge;
    logic [127:0]          n_sum, n_shift;
    logic                  n_byte;
    logic [112:0]          n_mant;
    logic [113:0]          n_m1;
    logic [112:0]          n_mant2;
    logic signed [E_W-1:0] n_ee2;
    logic                  n_inc;

    function automatic logic [127:0] shr_jam(input logic [127:0] x, input logic [E_W-1:0] n);
        logic [127:0] mask;
        logic [127:0] r;
        mask = ~({128{1'b1}} << n[6:0]);
        if (n >= E_W'(128)) begin
            r = {127'd0, |x};
        end else begin
            r = (x >> n[6:0]);
            r[0] = r[0] | (|(x & mask));
        end
        return r;
    endfunction

    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign o_strobe = r_strobe;
    assign o_res = r_res;

    always_comb begin
        n_mul_sum = r_acc + (r_mq[0] ? {1'b0, r_x} : 114'd0);
        n_div_t = (r_cnt == '0) ? r_rem : {r_rem[112:0], 1'b0};
        n_div_ge = n_div_t >= {1'b0, r_y};
        n_div_d = n_div_t - {1'b0, r_y};
        n_sum = r_sub ? (r_sig - r_ay) : (r_sig + r_ay);
        n_byte = r_sig[127:120] == '0;
        n_shift = n_byte ? {r_sig[119:0], 8'd0} : {r_sig[126:0], 1'b0};
        n_mant = r_sig[127:15];
        n_inc = r_sig[14] && ((|r_sig[13:0]) || n_mant[0]);
        n_m1 = {1'b0, n_mant} + {113'd0, n_inc};
        n_mant2 = n_m1[113] ? n_m1[113:1] : n_m1[112:0];
        n_ee2 = n_m1[113] ? r_e + E_W'(1) : r_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= i_job.kind;
                        r_sign <= i_job.sign;
                        r_sub <= i_job.eff_sub;
                        r_ex <= i_job.ex;
                        r_ey <= i_job.ey;
                        r_ysrc <= i_job.ysig;
                        case (i_job.kind)
                            K_SPECIAL: begin
                                r_res <= i_job.res;
                                r_strobe <= 1'b1;
                            end
                            K_ADD: begin
                                r_sig <= {1'b0, i_job.xsig, 14'd0};
                                r_ay <= {1'b0, i_job.ysig, 14'd0};
                                r_state <= S_ADD_ALIGN;
                            end
                            default: begin
                                r_sig <= {15'd0, i_job.xsig};
                                r_e <= i_job.ex + E_W'(15);
                                r_state <= S_PRE_A;
                            end
                        endcase
                    end
                end
                S_PRE_A: begin
                    if (r_sig[127]) begin
                        r_x <= r_sig[127:15];
                        r_ex <= r_e;
                        r_sig <= {15'd0, r_ysrc};
                        r_e <= r_ey + E_W'(15);
                        r_state <= S_PRE_B;
                    end else begin
                        r_sig <= n_shift;
                        r_e <= r_e - (n_byte ? E_W'(8) : E_W'(1));
                    end
                end
                S_PRE_B: begin
                    if (r_sig[127]) begin
                        r_y <= r_sig[127:15];
                        r_ey <= r_e;
                        r_cnt <= '0;
                        r_acc <= '0;
                        r_mq <= r_sig[127:15];
                        r_rem <= {1'b0, r_x};
                        r_state <= (r_kind == K_MUL) ? S_MUL : S_DIV;
                    end else begin
                        r_sig <= n_shift;
                        r_e <= r_e - (n_byte ? E_W'(8) : E_W'(1));
                    end
                end
                S_ADD_ALIGN: begin
                    r_ay <= shr_jam(r_ay, r_ex - r_ey);
                    r_state <= S_ADD_SUM;
                end
                S_ADD_SUM: begin
                    if (n_sum == '0) begin
                        r_res <= '0;
                        r_strobe <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_sig <= n_sum;
                        r_e <= r_ex + E_W'(1);
                        r_state <= S_NORM;
                    end
                end
                S_MUL: begin
                    if (r_cnt == 7'd113) begin
                        r_sig <= {r_acc[112:0], r_mq[112:99], r_mq[98] | (|r_mq[97:0])};
                        r_e <= r_ex + r_ey - E_BIAS + E_W'(1);
                        r_state <= S_NORM;
                    end else begin
                        r_acc <= {1'b0, n_mul_sum[113:1]};
                        r_mq <= {n_mul_sum[0], r_mq[112:1]};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd127) begin
                        r_sig <= {1'b0, r_q[126:1], r_q[0] | (r_rem != '0)};
                        r_e <= r_ex - r_ey + E_BIAS + E_W'(1);
                        r_state <= S_NORM;
                    end else begin
                        r_rem <= n_div_ge ? n_div_d : n_div_t;
                        r_q <= {r_q[125:0], n_div_ge};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_NORM: begin
                    if (r_sig[127]) begin
                        r_state <= S_JAM;
                    end else begin
                        r_sig <= n_shift;
                        r_e <= r_e - (n_byte ? E_W'(8) : E_W'(1));
                    end
                end
                S_JAM: begin
                    if (r_e < E_W'(1)) begin
                        r_sig <= shr_jam(r_sig, E_W'(1) - r_e);
                        r_e <= E_W'(1);
                    end
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (n_ee2 >= E_OVF) begin
                        r_res <= '{r_sign, EXP_MAX, 48'd0, 64'd0};
                    end else begin
                        r_res <= '{r_sign, n_mant2[112] ? n_ee2[14:0] : 15'd0,
                                   n_mant2[111:64], n_mant2[63:0]};
                    end
                    r_strobe <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/binary128_add_sub_mul_div_core.sv */
// binary128 add, subtract, multiply and divide, round to nearest even
// multiply runs a 113-step shift-add loop, divide a 127-step restoring quotient loop;
// one word in the back end at a time, results never stall
// a two-entry queue takes words while the back end works; busy when it is full
// synchronous active-low reset empties the queue and stops the back end
module binary128_add_sub_mul_div_core #(
    parameter int QUEUE_DEPTH = b128_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  b128_pkg::t_req i_req,
    output logic           o_strobe,
    output b128_pkg::t_res o_res
);
    import b128_pkg::*;

    t_job f_job, q_job;
    logic q_full, q_valid, q_pop;

    assign busy = q_full;

    b128_front u_front (
        .i_req (i_req),
        .o_job (f_job)
    );

    b128_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b128_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

/* sim/b128_checker.sv */
`timescale 1ns / 1ps

module b128_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  b128_pkg::t_req i_req,
    input  logic           i_strobe,
    input  b128_pkg::t_res i_res,
    output int             o_errors,
    output int             o_pending
);
    import b128_pkg::*;

    t_res expected_words[$];
    int   errors = 0;

    assign o_errors  = errors;

    function automatic int lead_zeros(logic [127:0] v);
        for (int i = 127; i >= 0; i--) begin
            if (v[i]) begin
                return 127 - i;
            end
        end
        return 128;
    endfunction

    function automatic logic [127:0] jam_right(logic [127:0] v, int n);
        if (n <= 0) begin
            return v;
        end
        if (n >= 128) begin
            return {127'b0, |v};
        end
        return (v >> n) | 128'((v << (128 - n)) != 0);
    endfunction

    // value is sig * 2^(e - 16383 - 127)
    function automatic t_res round_to_format(logic sgn, int e, logic [127:0] sig);
        int          c;
        int          ee;
        logic [113:0] mant;
        t_res        r;
        c = lead_zeros(sig);
        sig = sig << c;
        e = e - c;
        ee = e;
        if (e < 1) begin
            sig = jam_right(sig, 1 - e);
            ee = 1;
        end
        mant = {1'b0, sig[127:15]};
        if (sig[14] && (sig[13:0] != 0 || mant[0])) begin
            mant = mant + 1'b1;
        end
        if (mant[113]) begin
            mant = mant >> 1;
            ee++;
        end
        r.res_neg = sgn;
        if (ee >= 32767) begin
            r.res_exponent = EXP_MAX;
            {r.res_frac_high, r.res_frac_low} = '0;
        end else begin
            r.res_exponent = mant[112] ? ee[14:0] : 15'd0;
            {r.res_frac_high, r.res_frac_low} = mant[111:0];
        end
        return r;
    endfunction

    function automatic t_res quad_result(t_req q);
        logic         sa, sb, sr;
        logic [14:0]  ea, eb;
        logic [111:0] fa, fb;
        logic [127:0] x, y, acc, quo;
        logic [225:0] prod;
        int           ex, ey, sh;
        logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        t_res         r;
        sa = q.a_sign; ea = q.a_exponent; fa = {q.a_frac_high, q.a_frac_low};
        sb = q.b_sign; eb = q.b_exponent; fb = {q.b_frac_high, q.b_frac_low};
        if (q.opcode == OP_SUB) begin
            sb = ~sb;
        end
        a_nan = ea == EXP_MAX && fa != 0;
        b_nan = eb == EXP_MAX && fb != 0;
        a_inf = ea == EXP_MAX && fa == 0;
        b_inf = eb == EXP_MAX && fb == 0;
        a_zero = ea == 0 && fa == 0;
        b_zero = eb == 0 && fb == 0;
        sr = sa ^ sb;
        r = {1'b0, EXP_MAX, QUIET_HI, 64'd0};
        if (a_nan) begin
            r = {sa, EXP_MAX, fa | {QUIET_HI, 64'd0}};
        end else if (b_nan) begin
            r = {sb, EXP_MAX, fb | {QUIET_HI, 64'd0}};
        end else if (q.opcode == OP_ADD || q.opcode == OP_SUB) begin
            if (a_inf) begin
                if (!(b_inf && sa != sb)) r = {sa, ea, fa};
            end else if (b_inf) begin
                r = {sb, eb, fb};
            end else if (a_zero && b_zero) begin
                r = {sa & sb, 15'd0, 112'd0};
            end else if (a_zero) begin
                r = {sb, eb, fb};
            end else if (b_zero) begin
                r = {sa, ea, fa};
            end else begin
                if ({eb, fb} > {ea, fa}) begin
                    {sa, ea, fa, sb, eb, fb} = {sb, eb, fb, sa, ea, fa};
                end
                ex = ea != 0 ? int'(ea) : 1;
                ey = eb != 0 ? int'(eb) : 1;
                x = {15'd0, ea != 0, fa} << 14;
                y = jam_right({15'd0, eb != 0, fb} << 14, ex - ey);
                if (sa == sb) begin
                    acc = x + y;
                    r = round_to_format(sa, ex + 1, acc);
                end else begin
                    acc = x - y;
                    if (acc == 0) r = '0;
                    else r = round_to_format(sa, ex + 1, acc);
                end
            end
        end else begin
            if (q.opcode == OP_MUL && (a_inf || b_inf)) begin
                if (!(a_zero || b_zero)) r = {sr, EXP_MAX, 112'd0};
            end else if (q.opcode == OP_MUL && (a_zero || b_zero)) begin
                r = {sr, 15'd0, 112'd0};
            end else if (q.opcode == OP_DIV && a_inf) begin
                if (!b_inf) r = {sr, EXP_MAX, 112'd0};
            end else if (q.opcode == OP_DIV && b_inf) begin
                r = {sr, 15'd0, 112'd0};
            end else if (q.opcode == OP_DIV && b_zero) begin
                if (!a_zero) r = {sr, EXP_MAX, 112'd0};
            end else if (q.opcode == OP_DIV && a_zero) begin
                r = {sr, 15'd0, 112'd0};
            end else begin
                x = {15'd0, ea != 0, fa};
                ex = ea != 0 ? int'(ea) : 1;
                sh = lead_zeros(x) - 15;
                x = x << sh;
                ex = ex - sh;
                y = {15'd0, eb != 0, fb};
                ey = eb != 0 ? int'(eb) : 1;
                sh = lead_zeros(y) - 15;
                y = y << sh;
                ey = ey - sh;
                if (q.opcode == OP_MUL) begin
                    prod = {98'd0, x} * {98'd0, y};
                    acc = prod[225:98] | 128'(prod[97:0] != 0);
                    r = round_to_format(sr, ex + ey - 16383 + 1, acc);
                end else begin
                    quo = '0;
                    for (int i = 0; i < 127; i++) begin
                        if (i != 0) x = x << 1;
                        quo = quo << 1;
                        if (x >= y) begin
                            x = x - y;
                            quo[0] = 1'b1;
                        end
                    end
                    quo[0] = quo[0] | (x != 0);
                    r = round_to_format(sr, ex - ey + 16383 + 1, quo);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
        errors++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                expected_words.push_back(quad_result(i_req));
            end
            if (i_strobe) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", i_res, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_res.res_neg !== want.res_neg)
                        report_mismatch("res_neg", i_res.res_neg, want.res_neg);
                    if (i_res.res_exponent !== want.res_exponent)
                        report_mismatch("res_exponent", i_res.res_exponent,
                                        want.res_exponent);
                    if (i_res.res_frac_high !== want.res_frac_high)
                        report_mismatch("res_frac_high", i_res.res_frac_high,
                                        want.res_frac_high);
                    if (i_res.res_frac_low !== want.res_frac_low)
                        report_mismatch("res_frac_low", i_res.res_frac_low,
                                        want.res_frac_low);
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import b128_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam logic [127:0] ONE     = {1'b0, 15'd16383, 112'd0};
    localparam logic [127:0] TWO     = {1'b0, 15'd16384, 112'd0};
    localparam logic [127:0] THREE   = {1'b0, 15'd16384, 1'b1, 111'd0};
    localparam logic [127:0] HALF    = {1'b0, 15'd16382, 112'd0};
    localparam logic [127:0] ZERO    = '0;
    localparam logic [127:0] INF     = {1'b0, EXP_MAX, 112'd0};
    localparam logic [127:0] BIGGEST = {1'b0, 15'h7ffe, {112{1'b1}}};
    localparam logic [127:0] TINIEST = {1'b0, 15'd0, 111'd0, 1'b1};
    localparam logic [127:0] SUB_TOP = {1'b0, 15'd0, {112{1'b1}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_res o_res;
    int   errors;
    int   pending;
    int   idle_cycles = 0;
    int   op_count[4] = '{0, 0, 0, 0};

    always #5 i_clk = ~i_clk;

    binary128_add_sub_mul_div_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    b128_checker checker_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_req    (i_req),
        .i_strobe (o_strobe),
        .i_res    (o_res),
        .o_errors (errors),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic [1:0] op, logic [127:0] a, logic [127:0] b);
        t_req q;
        q.opcode = op;
        {q.a_sign, q.a_exponent, q.a_frac_high, q.a_frac_low} = a;
        {q.b_sign, q.b_exponent, q.b_frac_high, q.b_frac_low} = b;
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        op_count[op]++;
    endtask

    task automatic idle_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) n = 0;
        else if (r < 92) n = $urandom_range(1, 4);
        else n = $urandom_range(20, 400);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [111:0] rand_frac();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return raw[111:0] >> $urandom_range(0, 111);
            3: return {raw[111:100], 100'd0};
            default: return raw[111:0];
        endcase
    endfunction

    function automatic logic [14:0] rand_exp();
        case ($urandom_range(0, 19))
            0: return 15'd0;
            1: return EXP_MAX;
            2: return 15'h7ffe;
            3: return 15'd1;
            4, 5, 6, 7, 8, 9: return 15'(16383 + $urandom_range(0, 400) - 200);
            default: return 15'($urandom_range(1, 32766));
        endcase
    endfunction

    function automatic logic [127:0] rand_operand();
        logic [111:0] f;
        logic [14:0]  e;
        e = rand_exp();
        f = rand_frac();
        if (e == EXP_MAX && $urandom_range(0, 1)) f = '0;
        return {1'($urandom), e, f};
    endfunction

    function automatic logic [127:0] partner(logic [127:0] a);
        logic [127:0] b;
        int           d;
        b = rand_operand();
        case ($urandom_range(0, 4))
            0, 1: begin
                d = int'(a[126:112]) + $urandom_range(0, 8) - 4;
                if (d >= 0 && d < 32767) b[126:112] = 15'(d);
            end
            2: b = {1'($urandom), a[126:0] ^ 127'($urandom_range(0, 15))};
            default: ;
        endcase
        return b;
    endfunction

    initial begin
        logic [127:0] a;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_ADD, ONE, ONE);
        send_word(OP_SUB, INF, INF);
        send_word(OP_MUL, ZERO, {1'b1, INF[126:0]});
        send_word(OP_DIV, ZERO, ZERO);
        send_word(OP_DIV, INF, {1'b1, INF[126:0]});
        send_word(OP_DIV, ONE, INF);
        send_word(OP_DIV, {1'b1, THREE[126:0]}, ZERO);
        send_word(OP_ADD, {1'b1, 127'd0}, {1'b1, 127'd0});
        send_word(OP_SUB, {1'b1, 127'd0}, ZERO);
        send_word(OP_ADD, THREE, ZERO);
        send_word(OP_SUB, THREE, THREE);
        send_word(OP_ADD, {1'b1, EXP_MAX, 48'h1234, 64'h5}, ONE);
        send_word(OP_SUB, ONE, {1'b0, EXP_MAX, 48'h0, 64'h1});
        send_word(OP_MUL, {1'b1, EXP_MAX, {112{1'b1}}}, {1'b0, EXP_MAX, 112'd1});
        send_word(OP_MUL, BIGGEST, BIGGEST);
        send_word(OP_MUL, TINIEST, HALF);
        send_word(OP_MUL, SUB_TOP, {1'b1, 15'd16381, {112{1'b1}}});
        send_word(OP_DIV, BIGGEST, TINIEST);
        send_word(OP_ADD, SUB_TOP, TINIEST);
        send_word(OP_DIV, ONE, THREE);
        send_word(OP_ADD, BIGGEST, BIGGEST);
        send_word(OP_SUB, ONE, {1'b0, 15'd16382, {112{1'b1}}});
        send_word(OP_MUL, INF, {1'b1, TWO[126:0]});
        send_word(OP_ADD, {1'b1, INF[126:0]}, THREE);

        for (int i = 0; i < 930; i++) begin
            if (i == 400) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end else begin
                idle_gap();
            end
            a = rand_operand();
            send_word(2'($urandom), a, partner(a));
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);

        $display("covered %0d words: %0d add, %0d sub, %0d mul, %0d div",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("operands: zeros, subnormals, extremes, infinities and NaNs, random gaps");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/b128_pkg.sv
rtl/b128_front.sv
rtl/b128_queue.sv
rtl/b128_back.sv
rtl/binary128_add_sub_mul_div_core.sv
sim/b128_checker.sv
sim/testbench.sv
